// File: hdl/frc_pkg.sv
`timescale 1ns / 1ps

package frc_pkg;

    // field widths
    localparam int SLOT_W   = 4;
    localparam int SIZE_W   = 24;
    localparam int IDENT_W  = 32;
    localparam int HANDLE_W = 64;
    localparam int TOTAL_W  = 28;
    localparam int BUDGET_W = 24;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 24'd1048576;

    // request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_GET    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_EVICT  = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_GET    = 2'd2;
    localparam logic [1:0] KIND_REMOVE = 2'd3;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    // request to the shared add/subtract/compare unit
    typedef struct packed {
        t_alu_op              op;
        logic [TOTAL_W-1:0]   opa;
        logic [SIZE_W-1:0]    opb;
    } t_alu_in;

    typedef struct packed {
        logic [TOTAL_W-1:0]   res;
        logic                 over;
    } t_alu_out;

endpackage

// File: hdl/frc_ram.sv
`timescale 1ns / 1ps

module frc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/frc_alu.sv
`timescale 1ns / 1ps

module frc_alu (
    input  frc_pkg::t_alu_in                i_req,
    input  logic [frc_pkg::BUDGET_W-1:0]    i_budget,
    output frc_pkg::t_alu_out               o_rsp
);

    logic [frc_pkg::TOTAL_W:0] sum;

    // one adder, used for both running-total update and budget check
    always_comb begin
        if (i_req.op == frc_pkg::ALU_SUB) begin
            sum = {1'b0, i_req.opa}
                - {{(frc_pkg::TOTAL_W + 1 - frc_pkg::SIZE_W){1'b0}}, i_req.opb};
        end else begin
            sum = {1'b0, i_req.opa}
                + {{(frc_pkg::TOTAL_W + 1 - frc_pkg::SIZE_W){1'b0}}, i_req.opb};
        end
    end

    assign o_rsp.res  = sum[frc_pkg::TOTAL_W-1:0];
    assign o_rsp.over = sum > {{(frc_pkg::TOTAL_W + 1 - frc_pkg::BUDGET_W){1'b0}}, i_budget};

endmodule

// File: hdl/fifo_ring_cache_with_size_budget_top.sv
`timescale 1ns / 1ps
// Get: read slot, load result. Remove: read slot, subtract its size, load result. Add: walk
//   oldest slots, evicting occupied ones and passing empty ones while the entry does not fit;
//   evict the add slot's occupant; add the size; replay the walk, reporting each evicted slot;
//   store and report. Walk and replay go one slot per step via one shared adder and one read port.
// One request in flight at a time; ready is high only between requests.
// Reset (sync, active low): ring empty, total zero, both pointers zero, budget 1048576.
module fifo_ring_cache_with_size_budget_top #(
    parameter int SLOTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [frc_pkg::BUDGET_W-1:0]    i_cfg_data,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_req_type,
    input  logic [frc_pkg::SLOT_W-1:0]      i_slot,
    input  logic signed [frc_pkg::IDENT_W-1:0] i_ident,
    input  logic [frc_pkg::SIZE_W-1:0]      i_entry_size,
    input  logic [frc_pkg::HANDLE_W-1:0]    i_handle,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_kind,
    output logic                            o_last,
    output logic [frc_pkg::SLOT_W-1:0]      o_out_slot,
    output logic [frc_pkg::HANDLE_W-1:0]    o_out_handle,
    output logic                            o_hit,
    output logic [frc_pkg::TOTAL_W-1:0]     o_bytes_held
);

    localparam int PW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = frc_pkg::SLOT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_CHK,
        S_A_SUB,
        S_A_OVW,
        S_A_OVW2,
        S_A_TOT,
        S_E_ADDR,
        S_E_PUT,
        S_E_OVW,
        S_E_DONE,
        S_G_RD,
        S_G_PUT,
        S_R_RD,
        S_R_SUB,
        S_R_PUT
    } t_state;

    // control state
    t_state                         r_state, n_state;
    logic [SLOTS-1:0]               r_occ, n_occ;
    logic [SLOTS-1:0]               r_mask, n_mask;
    logic [frc_pkg::TOTAL_W-1:0]    r_total, n_total;
    logic [PW-1:0]                  r_oldest, n_oldest;
    logic [PW-1:0]                  r_add, n_add;
    logic [PW-1:0]                  r_start, n_start;
    logic [PW-1:0]                  r_eptr, n_eptr;
    logic [CW-1:0]                  r_steps, n_steps;
    logic                           r_ovw, n_ovw;
    logic [frc_pkg::BUDGET_W-1:0]   r_budget;
    logic                           r_out_valid, n_out_valid;

    // request and result payload
    logic [SW-1:0]                  r_slot, n_slot;
    logic [frc_pkg::IDENT_W-1:0]    r_ident, n_ident;
    logic [frc_pkg::SIZE_W-1:0]     r_size, n_size;
    logic [frc_pkg::HANDLE_W-1:0]   r_handle, n_handle;
    logic [frc_pkg::HANDLE_W-1:0]   r_aux_handle, n_aux_handle;
    logic [1:0]                     r_kind, n_kind;
    logic                           r_last, n_last;
    logic [SW-1:0]                  r_oslot, n_oslot;
    logic [frc_pkg::HANDLE_W-1:0]   r_ohandle, n_ohandle;
    logic                           r_hit, n_hit;
    logic [frc_pkg::TOTAL_W-1:0]    r_bytes, n_bytes;

    // memory and unit wiring
    logic [PW-1:0]                  rd_addr;
    logic                           mem_we;
    logic [frc_pkg::SIZE_W-1:0]     size_rd;
    logic [frc_pkg::IDENT_W-1:0]    ident_rd;
    logic [frc_pkg::HANDLE_W-1:0]   handle_rd;
    frc_pkg::t_alu_in               alu_req;
    frc_pkg::t_alu_out              alu_rsp;

    logic                           out_free;
    logic [PW-1:0]                  slot_addr;
    logic                           slot_ok;
    logic [PW+SW-1:0]               slot_wide;
    logic                           get_hit;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        return (p == PW'(SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [SW-1:0] f_oslot(input logic [PW-1:0] p);
        logic [PW+SW-1:0] w;
        w = {{SW{1'b0}}, p};
        return w[SW-1:0];
    endfunction

    // entry memories, shared read address
    frc_ram #(.WIDTH(frc_pkg::SIZE_W), .DEPTH(SLOTS)) u_sizes (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_add),
        .i_wdata (r_size),
        .i_raddr (rd_addr),
        .o_rdata (size_rd)
    );

    frc_ram #(.WIDTH(frc_pkg::IDENT_W), .DEPTH(SLOTS)) u_idents (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_add),
        .i_wdata (r_ident),
        .i_raddr (rd_addr),
        .o_rdata (ident_rd)
    );

    frc_ram #(.WIDTH(frc_pkg::HANDLE_W), .DEPTH(SLOTS)) u_handles (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_add),
        .i_wdata (r_handle),
        .i_raddr (rd_addr),
        .o_rdata (handle_rd)
    );

    frc_alu u_alu (
        .i_req    (alu_req),
        .i_budget (r_budget),
        .o_rsp    (alu_rsp)
    );

    // request slot as a ring index, plus range check
    assign slot_wide = {{PW{1'b0}}, r_slot};
    assign slot_addr = slot_wide[PW-1:0];
    assign slot_ok   = slot_wide < (PW + SW)'(SLOTS);
    assign get_hit   = slot_ok && r_occ[slot_addr] && (ident_rd == r_ident);

    assign out_free  = !r_out_valid || i_out_ready;

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_mask       = r_mask;
        n_total      = r_total;
        n_oldest     = r_oldest;
        n_add        = r_add;
        n_start      = r_start;
        n_eptr       = r_eptr;
        n_steps      = r_steps;
        n_ovw        = r_ovw;
        n_out_valid  = r_out_valid;
        n_slot       = r_slot;
        n_ident      = r_ident;
        n_size       = r_size;
        n_handle     = r_handle;
        n_aux_handle = r_aux_handle;
        n_kind       = r_kind;
        n_last       = r_last;
        n_oslot      = r_oslot;
        n_ohandle    = r_ohandle;
        n_hit        = r_hit;
        n_bytes      = r_bytes;
        rd_addr      = r_oldest;
        mem_we       = 1'b0;
        alu_req.op   = frc_pkg::ALU_ADD;
        alu_req.opa  = r_total;
        alu_req.opb  = r_size;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_slot   = i_slot;
                    n_ident  = $unsigned(i_ident);
                    n_size   = i_entry_size;
                    n_handle = i_handle;
                    unique case (i_req_type)
                        frc_pkg::REQ_ADD: begin
                            n_start = r_oldest;
                            n_mask  = '0;
                            n_steps = '0;
                            n_ovw   = 1'b0;
                            n_state = S_A_CHK;
                        end
                        frc_pkg::REQ_GET:    n_state = S_G_RD;
                        frc_pkg::REQ_REMOVE: n_state = S_R_RD;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end

            // walk oldest slots while the new entry does not fit
            S_A_CHK: begin
                rd_addr = r_oldest;
                if ((|r_occ) && alu_rsp.over) begin
                    if (r_occ[r_oldest]) begin
                        n_state = S_A_SUB;
                    end else begin
                        n_oldest = f_next(r_oldest);
                        n_steps  = r_steps + 1'b1;
                    end
                end else begin
                    n_state = S_A_OVW;
                end
            end

            S_A_SUB: begin
                rd_addr           = r_oldest;
                alu_req.op        = frc_pkg::ALU_SUB;
                alu_req.opb       = size_rd;
                n_total           = alu_rsp.res;
                n_occ[r_oldest]   = 1'b0;
                n_mask[r_oldest]  = 1'b1;
                n_oldest          = f_next(r_oldest);
                n_steps           = r_steps + 1'b1;
                n_state           = S_A_CHK;
            end

            S_A_OVW: begin
                rd_addr = r_add;
                n_state = S_A_OVW2;
            end

            // occupant of the add slot is evicted too
            S_A_OVW2: begin
                rd_addr = r_add;
                if (r_occ[r_add]) begin
                    alu_req.op   = frc_pkg::ALU_SUB;
                    alu_req.opb  = size_rd;
                    n_total      = alu_rsp.res;
                    n_occ[r_add] = 1'b0;
                    n_ovw        = 1'b1;
                    n_aux_handle = handle_rd;
                    n_oldest     = f_next(r_oldest);
                end
                n_state = S_A_TOT;
            end

            S_A_TOT: begin
                n_total      = alu_rsp.res;
                n_occ[r_add] = 1'b1;
                n_eptr       = r_start;
                n_state      = S_E_ADDR;
            end

            // replay walked slots, report each evicted one
            S_E_ADDR: begin
                rd_addr = r_eptr;
                if (r_steps == '0) begin
                    n_state = S_E_OVW;
                end else if (r_mask[r_eptr]) begin
                    n_state = S_E_PUT;
                end else begin
                    n_eptr  = f_next(r_eptr);
                    n_steps = r_steps - 1'b1;
                end
            end

            S_E_PUT: begin
                rd_addr = r_eptr;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = frc_pkg::KIND_EVICT;
                    n_last      = 1'b0;
                    n_oslot     = f_oslot(r_eptr);
                    n_ohandle   = handle_rd;
                    n_hit       = 1'b0;
                    n_bytes     = r_total;
                    n_eptr      = f_next(r_eptr);
                    n_steps     = r_steps - 1'b1;
                    n_state     = S_E_ADDR;
                end
            end

            S_E_OVW: begin
                if (!r_ovw) begin
                    n_state = S_E_DONE;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = frc_pkg::KIND_EVICT;
                    n_last      = 1'b0;
                    n_oslot     = f_oslot(r_add);
                    n_ohandle   = r_aux_handle;
                    n_hit       = 1'b0;
                    n_bytes     = r_total;
                    n_state     = S_E_DONE;
                end
            end

            // store the entry and report the slot
            S_E_DONE: begin
                if (out_free) begin
                    mem_we      = 1'b1;
                    n_out_valid = 1'b1;
                    n_kind      = frc_pkg::KIND_ADD;
                    n_last      = 1'b1;
                    n_oslot     = f_oslot(r_add);
                    n_ohandle   = '0;
                    n_hit       = 1'b0;
                    n_bytes     = r_total;
                    n_add       = f_next(r_add);
                    n_state     = S_IDLE;
                end
            end

            S_G_RD: begin
                rd_addr = slot_addr;
                n_state = S_G_PUT;
            end

            S_G_PUT: begin
                rd_addr = slot_addr;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = frc_pkg::KIND_GET;
                    n_last      = 1'b1;
                    n_oslot     = r_slot;
                    n_ohandle   = get_hit ? handle_rd : '0;
                    n_hit       = get_hit;
                    n_bytes     = r_total;
                    n_state     = S_IDLE;
                end
            end

            S_R_RD: begin
                rd_addr = slot_addr;
                n_state = S_R_SUB;
            end

            S_R_SUB: begin
                rd_addr      = slot_addr;
                n_aux_handle = '0;
                if (slot_ok && r_occ[slot_addr]) begin
                    alu_req.op       = frc_pkg::ALU_SUB;
                    alu_req.opb      = size_rd;
                    n_total          = alu_rsp.res;
                    n_occ[slot_addr] = 1'b0;
                    n_aux_handle     = handle_rd;
                end
                n_state = S_R_PUT;
            end

            S_R_PUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = frc_pkg::KIND_REMOVE;
                    n_last      = 1'b1;
                    n_oslot     = r_slot;
                    n_ohandle   = r_aux_handle;
                    n_hit       = 1'b0;
                    n_bytes     = r_total;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // state, budget and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_mask      <= '0;
            r_total     <= '0;
            r_oldest    <= '0;
            r_add       <= '0;
            r_start     <= '0;
            r_eptr      <= '0;
            r_steps     <= '0;
            r_ovw       <= 1'b0;
            r_out_valid <= 1'b0;
            r_budget    <= frc_pkg::BUDGET_RESET;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_mask      <= n_mask;
            r_total     <= n_total;
            r_oldest    <= n_oldest;
            r_add       <= n_add;
            r_start     <= n_start;
            r_eptr      <= n_eptr;
            r_steps     <= n_steps;
            r_ovw       <= n_ovw;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_budget <= i_cfg_data;
            end
        end
        r_slot       <= n_slot;
        r_ident      <= n_ident;
        r_size       <= n_size;
        r_handle     <= n_handle;
        r_aux_handle <= n_aux_handle;
        r_kind       <= n_kind;
        r_last       <= n_last;
        r_oslot      <= n_oslot;
        r_ohandle    <= n_ohandle;
        r_hit        <= n_hit;
        r_bytes      <= n_bytes;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_last       = r_last;
    assign o_out_slot   = r_oslot;
    assign o_out_handle = r_ohandle;
    assign o_hit        = r_hit;
    assign o_bytes_held = r_bytes;

    // an empty ring holds no bytes
    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == '0) |-> (r_total == '0))
        else $error("total nonzero with ring empty");

    // the eviction walk never laps the ring
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= CW'(SLOTS))
        else $error("eviction walk exceeded ring size");

    // eviction notices never close a request
    a_evict_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == frc_pkg::KIND_EVICT)) |-> !r_last)
        else $error("eviction notice marked last");

    // replay of evicted slots happens after the final total is in place and ends before the add finishes
    a_replay_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_E_DONE) |-> (r_steps == '0))
        else $error("add finished with walked slots not replayed");

endmodule
